// File: src/pbfl_pkg.sv
package pbfl_pkg;

   // Default number of buffers in the pool.
   localparam int DEFAULT_BUF_COUNT = 8;

   // Fixed widths of the command and result fields.
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TAKE    = 2'd0,
      ACT_ENQUEUE = 2'd1,
      ACT_SERVICE = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_POOL_EMPTY = 2'd1,
      STAT_RX_EMPTY   = 2'd2
   } status_type;

endpackage

// File: src/packet_buffer_free_list.sv
// Packet buffer pool: buffer indices kept as two linked stacks, the free list
// and a last-in first-out receive queue, sharing one link memory.
// The req_ channel carries one command item (action, buffer_index); each item
// produces exactly one result item on the rsp_ channel (buffer_out, status,
// queue_stopped, queue_woken).
// Enqueue and release, and any take or service that finds its stack empty,
// finish in the accept cycle: the result is registered at the accept edge.
// A take or service of a non-empty stack reads the head's link from the
// memory, so it passes through the S_LINK state, where the synchronous read
// of the link memory returns the link and the result is registered; no new
// item is taken while in S_LINK, so a new item waits until the lookup is done.
// A result sits in an output register; req_ready stays high while that
// register is empty or being emptied and no lookup is pending, so a stalled
// receiver holds off new items once one result is waiting.
// Reset gives a full free list (highest index on top), an empty receive queue
// and a clear stop flag, with no clearing pass of the link memory.
module packet_buffer_free_list
   import pbfl_pkg::*;
#(
   parameter int BUF_COUNT = DEFAULT_BUF_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [INDEX_W-1:0]  req_buffer_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [INDEX_W-1:0]  rsp_buffer_out,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_queue_stopped,
   output logic                rsp_queue_woken
);

   localparam int ADDR_W = $clog2(BUF_COUNT);
   localparam int LINK_W = $clog2(BUF_COUNT + 1);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BUF_COUNT);

   typedef enum logic {
      S_IDLE,
      S_LINK
   } state_type;

   state_type              state_ff, state_in;
   action_type             act_ff, act_in;
   logic [LINK_W-1:0]      free_head_ff, free_head_in;
   logic [LINK_W-1:0]      rx_head_ff, rx_head_in;
   logic                   stop_ff, stop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]     rsp_buffer_out_ff, rsp_buffer_out_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_stopped_ff, rsp_stopped_in;
   logic                   rsp_woken_ff, rsp_woken_in;

   logic                   accept;
   logic                   free_empty;
   logic                   rx_empty;
   logic                   idx_ok;
   logic                   wake;
   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [LINK_W-1:0]      mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [LINK_W-1:0]      mem_rd_data;

   pbfl_link_mem #(
      .BUF_COUNT (BUF_COUNT)
   ) u_link_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign free_empty = (free_head_ff >= NULL_LINK);
   assign rx_empty   = (rx_head_ff >= NULL_LINK);
   assign idx_ok     = (32'(req_buffer_index) < 32'(BUF_COUNT));
   // A buffer returned to an empty pool while stopped restarts transmit.
   assign wake       = stop_ff && free_empty;
   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;

   always_comb begin
      state_in          = state_ff;
      act_in            = act_ff;
      free_head_in      = free_head_ff;
      rx_head_in        = rx_head_ff;
      stop_in           = stop_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_buffer_out_in = rsp_buffer_out_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_stopped_in    = rsp_stopped_ff;
      rsp_woken_in      = rsp_woken_ff;
      mem_wr_en         = 1'b0;
      mem_wr_addr       = ADDR_W'(req_buffer_index);
      mem_wr_data       = rx_head_ff;
      mem_rd_en         = 1'b0;
      mem_rd_addr       = ADDR_W'(free_head_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in            = action_type'(req_action);
               rsp_buffer_out_in = '0;
               rsp_status_in     = STAT_OK;
               rsp_woken_in      = 1'b0;
               rsp_stopped_in    = stop_ff;
               rsp_valid_in      = 1'b1;
               case (action_type'(req_action))
                  ACT_TAKE: begin
                     if (free_empty) begin
                        rsp_status_in = STAT_POOL_EMPTY;
                     end else begin
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = ADDR_W'(free_head_ff);
                        rsp_valid_in = 1'b0;
                        state_in     = S_LINK;
                     end
                  end
                  ACT_ENQUEUE: begin
                     if (idx_ok) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = rx_head_ff;
                        rx_head_in  = LINK_W'(req_buffer_index);
                     end
                  end
                  ACT_SERVICE: begin
                     if (rx_empty) begin
                        rsp_status_in = STAT_RX_EMPTY;
                     end else begin
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = ADDR_W'(rx_head_ff);
                        rsp_valid_in = 1'b0;
                        state_in     = S_LINK;
                     end
                  end
                  ACT_RELEASE: begin
                     if (idx_ok) begin
                        mem_wr_en      = 1'b1;
                        mem_wr_data    = free_head_ff;
                        free_head_in   = LINK_W'(req_buffer_index);
                        stop_in        = stop_ff && !wake;
                        rsp_woken_in   = wake;
                        rsp_stopped_in = stop_ff && !wake;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LINK: begin
            // The head's link has arrived from the memory.
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_status_in = STAT_OK;
            if (act_ff == ACT_TAKE) begin
               free_head_in      = mem_rd_data;
               stop_in           = stop_ff || (mem_rd_data >= NULL_LINK);
               rsp_buffer_out_in = INDEX_W'(free_head_ff);
               rsp_stopped_in    = stop_ff || (mem_rd_data >= NULL_LINK);
               rsp_woken_in      = 1'b0;
            end else begin
               // Pop the receive queue and push the buffer onto the free list.
               rx_head_in        = mem_rd_data;
               mem_wr_en         = 1'b1;
               mem_wr_addr       = ADDR_W'(rx_head_ff);
               mem_wr_data       = free_head_ff;
               free_head_in      = rx_head_ff;
               stop_in           = stop_ff && !wake;
               rsp_buffer_out_in = INDEX_W'(rx_head_ff);
               rsp_stopped_in    = stop_ff && !wake;
               rsp_woken_in      = wake;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_ff       <= ACT_TAKE;
         free_head_ff <= LINK_W'(BUF_COUNT - 1);
         rx_head_ff   <= NULL_LINK;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         free_head_ff <= free_head_in;
         rx_head_ff   <= rx_head_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_buffer_out_ff <= rsp_buffer_out_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_stopped_ff    <= rsp_stopped_in;
      rsp_woken_ff      <= rsp_woken_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_buffer_out    = rsp_buffer_out_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_queue_stopped = rsp_stopped_ff;
   assign rsp_queue_woken   = rsp_woken_ff;

   // While a link lookup is in flight the result register must be empty.
   a_link_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> !rsp_valid_ff)
      else $error("result register occupied during link lookup");

   // Every accepted item yields a result or a pending link lookup.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || state_ff == S_LINK))
      else $error("accepted item produced neither result nor lookup");

   // Transmit can only be stopped while the pool is empty.
   a_stop_means_empty: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> free_empty)
      else $error("stop flag set with buffers on the free list");

   // A wake always leaves the queue running.
   a_wake_clears_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_woken_ff) |-> !rsp_stopped_ff)
      else $error("wake reported while still stopped");

endmodule

// File: src/pbfl_ram.sv
module pbfl_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pbfl_link_mem.sv
module pbfl_link_mem
   import pbfl_pkg::*;
#(
   parameter int BUF_COUNT = DEFAULT_BUF_COUNT,
   localparam int ADDR_W = $clog2(BUF_COUNT),
   localparam int LINK_W = $clog2(BUF_COUNT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [LINK_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [LINK_W-1:0] rd_data
);

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BUF_COUNT);

   // An entry that was never written since reset reads as its reset link:
   // the previous index, or the null link for entry zero.
   logic [BUF_COUNT-1:0] written_ff;
   logic [BUF_COUNT-1:0] written_in;
   logic                 rd_written_ff;
   logic [ADDR_W-1:0]    rd_addr_ff;
   logic [LINK_W-1:0]    ram_data;

   pbfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (BUF_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
      if (rd_en) begin
         rd_written_ff <= written_ff[rd_addr];
         rd_addr_ff    <= rd_addr;
      end
   end

   always_comb begin
      if (rd_written_ff) begin
         rd_data = ram_data;
      end else if (rd_addr_ff == '0) begin
         rd_data = NULL_LINK;
      end else begin
         rd_data = LINK_W'(rd_addr_ff) - LINK_W'(1);
      end
   end

endmodule
